// ===== src/bsed_pkg.sv =====
// types, codes and character constants shared by the backslash escape decoder
// no dependencies; compiled before every other file of the block
package bsed_pkg;

  // command codes of an input beat
  localparam logic [1:0] CMD_TEXT  = 2'd0;
  localparam logic [1:0] CMD_BREAK = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // configuration register indexes
  localparam logic REG_ESCAPES_ENABLED  = 1'b0;
  localparam logic REG_SUPPRESS_NEWLINE = 1'b1;

  // character constants
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOWER_C   = 8'h63;

  // octal sequences end after this many digits
  localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESCAPE,
    MODE_OCTAL
  } mode_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_echo;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    mode_t      decode_mode;
    logic [1:0] octal_digit_count;
    logic [7:0] octal_value;
    logic       output_stopped;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    decode_mode:       MODE_PLAIN,
    octal_digit_count: 2'd0,
    octal_value:       8'd0,
    output_stopped:    1'b0
  };

  // map the byte after a backslash to its control byte; hit is low when unmapped
  function automatic logic [8:0] escape_map(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h61:        r = {1'b1, 8'd7};
      8'h62:        r = {1'b1, 8'd8};
      8'h65:        r = {1'b1, CH_ESC};
      8'h66:        r = {1'b1, 8'd12};
      8'h6E:        r = {1'b1, CH_NEWLINE};
      8'h72:        r = {1'b1, 8'd13};
      8'h74:        r = {1'b1, 8'd9};
      8'h76:        r = {1'b1, 8'd11};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      default:      r = {1'b0, 8'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== src/backslash_escape_decoder_top.sv =====
// top level of the backslash escape decoder: state, configuration, handshakes
// depends on bsed_pkg, bsed_decode and bsed_out_buf
//
// Decodes echo argument text one beat at a time. An input beat is a text byte, an
// argument break or an end of command; each one yields zero, one or two result
// beats. Text streams at one beat per cycle while out_ready is high: the beat is
// decoded in the cycle it is accepted and its results land in a two-slot output
// buffer. A beat with two results (an unknown escape, a closed octal value and a
// byte, a break or end after a pending sequence) holds in_ready low while the
// second result drains. in_ready follows out_ready in the same cycle when only the
// output slot is full. The user must write configuration (escapes_enabled,
// suppress_newline) via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module backslash_escape_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsed_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsed_pkg::out_item_t out_data
);
  import bsed_pkg::*;

  // configuration registers
  logic escapes_enabled;
  logic suppress_newline;

  // decoder state and next value
  dec_state_t st;
  dec_state_t st_next;

  logic [1:0] res_count;
  out_item_t  res0;
  out_item_t  res1;
  logic       in_accept;
  logic       space;

  assign in_ready  = space;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escapes_enabled  <= 1'b0;
      suppress_newline <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPES_ENABLED:  escapes_enabled  <= cfg_data;
        REG_SUPPRESS_NEWLINE: suppress_newline <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state only moves on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= DEC_STATE_RESET;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  bsed_decode u_decode (
    .item             (in_data),
    .st               (st),
    .escapes_enabled  (escapes_enabled),
    .suppress_newline (suppress_newline),
    .st_next          (st_next),
    .res_count        (res_count),
    .res0             (res0),
    .res1             (res1)
  );

  bsed_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (in_accept),
    .push_count (res_count),
    .push0      (res0),
    .push1      (res1),
    .space      (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // end of command leaves the decoder in its reset state
  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.command == CMD_END |=>
      st.decode_mode == MODE_PLAIN && !st.output_stopped &&
      st.octal_digit_count == 2'd0)
    else $error("decoder state not cleared after end of command");

  // the final beat of a command is also the last beat of its run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_echo |-> out_data.last_of_run)
    else $error("end_of_echo without last_of_run");

  // an empty beat only closes a command
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_byte |-> out_data.end_of_echo && out_data.out_byte == 8'd0)
    else $error("empty result beat outside end of command");

  // a stalled output blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

// ===== src/bsed_decode.sv =====
// decode logic for one input beat: next state and up to two result beats
// depends on bsed_pkg
module bsed_decode (
  input  bsed_pkg::in_item_t   item,
  input  bsed_pkg::dec_state_t st,
  input  logic                 escapes_enabled,
  input  logic                 suppress_newline,
  output bsed_pkg::dec_state_t st_next,
  output logic [1:0]           res_count,
  output bsed_pkg::out_item_t  res0,
  output bsed_pkg::out_item_t  res1
);
  import bsed_pkg::*;

  logic [7:0] byt [2];
  logic [1:0] n;
  logic       pend_has;
  logic [7:0] pend_byte;
  logic       is_digit;
  logic [7:0] oct_acc;
  logic [8:0] esc;
  logic [7:0] b;

  always_comb begin
    b         = item.text_byte;
    n         = 2'd0;
    byt[0]    = 8'd0;
    byt[1]    = 8'd0;
    st_next   = st;
    pend_has  = (st.decode_mode == MODE_ESCAPE) || (st.decode_mode == MODE_OCTAL);
    pend_byte = (st.decode_mode == MODE_ESCAPE) ? CH_BACKSLASH : st.octal_value;
    is_digit  = (b[7:3] == CH_ZERO[7:3]);
    oct_acc   = {st.octal_value[4:0], b[2:0]};
    esc       = escape_map(b);

    case (item.command)
      CMD_END: begin
        if (!st.output_stopped) begin
          if (pend_has) begin
            byt[n[0]] = pend_byte;
            n = n + 2'd1;
          end
          if (!suppress_newline) begin
            byt[n[0]] = CH_NEWLINE;
            n = n + 2'd1;
          end
        end
        st_next = DEC_STATE_RESET;
      end
      CMD_BREAK: begin
        if (!st.output_stopped) begin
          if (pend_has) begin
            byt[n[0]] = pend_byte;
            n = n + 2'd1;
          end
          byt[n[0]] = CH_SPACE;
          n = n + 2'd1;
          st_next.decode_mode       = MODE_PLAIN;
          st_next.octal_digit_count = 2'd0;
          st_next.octal_value       = 8'd0;
        end
      end
      CMD_TEXT: begin
        if (!st.output_stopped) begin
          case (st.decode_mode)
            MODE_ESCAPE: begin
              st_next.decode_mode = MODE_PLAIN;
              if (esc[8]) begin
                byt[0] = esc[7:0];
                n = 2'd1;
              end else if (b == CH_LOWER_C) begin
                st_next.output_stopped = 1'b1;
              end else if (b == CH_ZERO) begin
                st_next.decode_mode       = MODE_OCTAL;
                st_next.octal_digit_count = 2'd0;
                st_next.octal_value       = 8'd0;
              end else begin
                // unknown sequence keeps the backslash
                byt[0] = CH_BACKSLASH;
                byt[1] = b;
                n = 2'd2;
              end
            end
            MODE_OCTAL: begin
              if (is_digit) begin
                if (st.octal_digit_count + 2'd1 == OCTAL_MAX_DIGITS) begin
                  byt[0] = oct_acc;
                  n = 2'd1;
                  st_next.decode_mode       = MODE_PLAIN;
                  st_next.octal_digit_count = 2'd0;
                  st_next.octal_value       = 8'd0;
                end else begin
                  st_next.octal_digit_count = st.octal_digit_count + 2'd1;
                  st_next.octal_value       = oct_acc;
                end
              end else begin
                // close the octal value, then handle the byte as in plain mode (a backslash may open an escape)
                byt[0] = st.octal_value;
                n = 2'd1;
                st_next.octal_digit_count = 2'd0;
                st_next.octal_value       = 8'd0;
                if (b == CH_BACKSLASH && escapes_enabled) begin
                  st_next.decode_mode = MODE_ESCAPE;
                end else begin
                  st_next.decode_mode = MODE_PLAIN;
                  byt[1] = b;
                  n = 2'd2;
                end
              end
            end
            default: begin
              if (b == CH_BACKSLASH && escapes_enabled) begin
                st_next.decode_mode = MODE_ESCAPE;
              end else begin
                st_next.decode_mode = MODE_PLAIN;
                byt[0] = b;
                n = 2'd1;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // end of command always yields a beat, an empty one when nothing is due
  always_comb begin
    res0 = '0;
    res1 = '0;
    res_count = n;
    if (item.command == CMD_END && n == 2'd0) begin
      res_count = 2'd1;
      res0.end_of_echo = 1'b1;
      res0.last_of_run = 1'b1;
    end else begin
      res0.out_byte = byt[0];
      res0.has_byte = 1'b1;
      res1.out_byte = byt[1];
      res1.has_byte = 1'b1;
      if (n == 2'd1) begin
        res0.last_of_run = 1'b1;
        res0.end_of_echo = (item.command == CMD_END);
      end
      if (n == 2'd2) begin
        res1.last_of_run = 1'b1;
        res1.end_of_echo = (item.command == CMD_END);
      end
    end
  end

endmodule

// ===== src/bsed_out_buf.sv =====
// two-slot result buffer: slot 0 drives the output, slot 1 holds a second beat
// depends on bsed_pkg
module bsed_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          push_count,
  input  bsed_pkg::out_item_t push0,
  input  bsed_pkg::out_item_t push1,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output bsed_pkg::out_item_t out_data
);
  import bsed_pkg::*;

  out_item_t slot0;
  out_item_t slot1;
  logic      valid0;
  logic      valid1;
  logic      pop;

  assign pop       = valid0 && out_ready;
  assign space     = !valid1 && (!valid0 || out_ready);
  assign out_valid = valid0;
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (push) begin
      valid0 <= (push_count != 2'd0);
      valid1 <= (push_count == 2'd2);
    end else if (pop) begin
      valid0 <= valid1;
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= push0;
      slot1 <= push1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule
